/* design/hotplate_thermostat_bar_display_unit_assert.svh */
// Assertion macros shared by the thermostat bar display RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef HOTPLATE_THERMOSTAT_BAR_DISPLAY_UNIT_ASSERT_SVH
`define HOTPLATE_THERMOSTAT_BAR_DISPLAY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define HTBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HTBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/htbd_pkg.sv */
// Shared types, widths and constants of the thermostat bar display.
// No dependencies; every design module and interface imports this package.
`default_nettype none

package htbd_pkg;

  // Strip geometry
  localparam int PIXEL_COUNT = 11;
  localparam int PIX_IDX_W   = $clog2(PIXEL_COUNT);

  // Field widths
  localparam int TEMP_W   = 14;
  localparam int TGT_W    = 7;
  localparam int STEP_W   = 6;
  localparam int BRIGHT_W = 8;
  localparam int HOLD_W   = 8;
  localparam int PIDX_W   = 4;
  localparam int LEVEL_W  = 8;
  localparam int BAR_W    = 16;
  localparam int FILT_W   = 18;
  localparam int FULL_SCALE_DEG = 90;

  // Filter divide by ten: offset numerator, multiply by reciprocal
  localparam int FN_W        = 24;
  localparam int DIV10_IN_W  = 22;
  localparam int DIV10_P_W   = 2 * DIV10_IN_W;
  localparam int REC10_SHIFT = 25;
  localparam logic [DIV10_IN_W-1:0] REC10 =
    DIV10_IN_W'(((1 << REC10_SHIFT) + 9) / 10);
  localparam int FILT_BIAS = 5 + 10 * (1 << (FILT_W - 1));
  localparam logic [FILT_W-1:0] FILT_OFS = FILT_W'(1 << (FILT_W - 1));

  // Bar length: f * brightness * (N-1) / (90*256) = (prod >> 9) / 45
  localparam int BSCALE_W    = BRIGHT_W + PIX_IDX_W;
  localparam int PROD_W      = FILT_W - 1 + BSCALE_W;
  localparam int BAR_SHIFT   = 9;
  localparam int BAR_DIV     = (FULL_SCALE_DEG * 256) / (1 << BAR_SHIFT);
  localparam int U_W         = 22;
  localparam int REC45_SHIFT = 28;
  localparam int REC45_W     = 23;
  localparam logic [REC45_W-1:0] REC45 =
    REC45_W'(((1 << REC45_SHIFT) + BAR_DIV - 1) / BAR_DIV);
  localparam int QP_W   = U_W + REC45_W;
  localparam int BARQ_W = 17;

  // Dot position: (90*N - target*(N-1)) / 90
  localparam int DOT_W       = 14;
  localparam int DOTM_W      = 13;
  localparam int REC90_SHIFT = 20;
  localparam int REC90_W     = 14;
  localparam logic [REC90_W-1:0] REC90 =
    REC90_W'(((1 << REC90_SHIFT) + FULL_SCALE_DEG - 1) / FULL_SCALE_DEG);
  localparam int DOTP_W   = DOTM_W + REC90_W + 1;
  localparam int DOTPOS_W = 7;
  localparam logic [DOT_W-1:0] DOT_N = DOT_W'(FULL_SCALE_DEG * PIXEL_COUNT);

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int REG_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Reset values
  localparam logic [BRIGHT_W-1:0]      BRIGHT_RST = BRIGHT_W'(16);
  localparam logic signed [TEMP_W-1:0] LIMIT_RST  = TEMP_W'(800);
  localparam logic [STEP_W-1:0]        STEP_RST   = STEP_W'(10);
  localparam logic [TGT_W-1:0]         TMIN_RST   = TGT_W'(10);
  localparam logic [TGT_W-1:0]         TMAX_RST   = TGT_W'(90);
  localparam logic [HOLD_W-1:0]        HOLD_RST   = HOLD_W'(100);
  localparam logic [TGT_W-1:0]         TARGET_RST = TGT_W'(60);

  typedef enum logic [2:0] {
    REG_BRIGHTNESS  = 3'd0,
    REG_SWITCH_LIM  = 3'd1,
    REG_TARGET_STEP = 3'd2,
    REG_TARGET_MIN  = 3'd3,
    REG_TARGET_MAX  = 3'd4,
    REG_HOLD_TICKS  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_STARTUP   = 3'd0,
    MODE_TEMP      = 3'd1,
    MODE_TARGET    = 3'd2,
    MODE_TO_TARGET = 3'd3,
    MODE_TO_TEMP   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DRAW_NONE  = 2'd0,
    DRAW_BLACK = 2'd1,
    DRAW_BAR   = 2'd2,
    DRAW_DOT   = 2'd3
  } draw_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0]      brightness;
    logic signed [TEMP_W-1:0] switch_temp_limit;
    logic [STEP_W-1:0]        target_step;
    logic [TGT_W-1:0]         target_min;
    logic [TGT_W-1:0]         target_max;
    logic [HOLD_W-1:0]        hold_ticks;
    logic [BSCALE_W-1:0]      bar_scale;
  } cfg_t;

  typedef struct packed {
    logic                 heat;
    logic                 over;
    draw_t                kind;
    logic [BAR_W-1:0]     bar;
    logic                 dot_hit;
    logic [PIX_IDX_W-1:0] dot_pos;
  } frame_t;

endpackage

`default_nettype wire

/* design/htbd_in_if.sv */
// Input channel of the thermostat bar display: one tick per beat.
// Depends on htbd_pkg for field widths.
`default_nettype none

interface htbd_in_if;
  import htbd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] coil_temp;
  logic signed [TEMP_W-1:0] switch_temp;
  logic                     up_press;
  logic                     down_press;

  modport source (
    output valid, coil_temp, switch_temp, up_press, down_press,
    input  ready
  );

  modport sink (
    input  valid, coil_temp, switch_temp, up_press, down_press,
    output ready
  );
endinterface

`default_nettype wire

/* design/htbd_out_if.sv */
// Result channel of the thermostat bar display: one pixel or status per beat.
// Depends on htbd_pkg for field widths.
`default_nettype none

interface htbd_out_if;
  import htbd_pkg::*;

  logic               valid;
  logic               ready;
  logic               heater_on;
  logic               overtemp;
  logic               pixel_valid;
  logic [PIDX_W-1:0]  pixel_index;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] red_level;
  logic               last;

  modport source (
    output valid, heater_on, overtemp, pixel_valid, pixel_index,
           green_level, red_level, last,
    input  ready
  );

  modport sink (
    input  valid, heater_on, overtemp, pixel_valid, pixel_index,
           green_level, red_level, last,
    output ready
  );
endinterface

`default_nettype wire

/* design/hotplate_thermostat_bar_display_unit.sv */
// Hotplate thermostat with LED bar display: tick in, pixel beats out.
// A taken beat passes stage regs s1 and s2, the command queue, the back-end
// frame register and the output register. A drawing tick gives PIXEL_COUNT
// beats (11), others one; the back-end emits one beat per cycle unless stalled.
// Reset: synchronous rst_n sets startup mode, 60 degree target, zero filter,
// empty queue and register defaults; no clearing pass, input taken at once.
`default_nettype none

module hotplate_thermostat_bar_display_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  htbd_in_if.sink                              in_ch,
  htbd_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [htbd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [htbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [htbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import htbd_pkg::*;

  cfg_t              cfg;
  frame_t            push_data;
  frame_t            q_data;
  logic              push;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  htbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  htbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .count     (q_count)
  );

  htbd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (q_data),
    .q_count (q_count),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* design/htbd_regs.sv */
// APB-style configuration registers of the thermostat bar display.
// Depends on htbd_pkg; feeds cfg_t to the front and back ends.
`default_nettype none

module htbd_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [htbd_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [htbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [htbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output htbd_pkg::cfg_t                       cfg
);
  import htbd_pkg::*;

  logic [BRIGHT_W-1:0]      brightness_r;
  logic signed [TEMP_W-1:0] limit_r;
  logic [STEP_W-1:0]        step_r;
  logic [TGT_W-1:0]         tmin_r;
  logic [TGT_W-1:0]         tmax_r;
  logic [HOLD_W-1:0]        hold_r;
  logic [BSCALE_W-1:0]      bar_scale_r;
  logic [BSCALE_W-1:0]      bar_scale_nxt;
  logic                     wr_en;
  reg_idx_t                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);

  // Write decoded register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RST;
      limit_r      <= LIMIT_RST;
      step_r       <= STEP_RST;
      tmin_r       <= TMIN_RST;
      tmax_r       <= TMAX_RST;
      hold_r       <= HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BRIGHTNESS:  brightness_r <= pwdata[BRIGHT_W-1:0];
        REG_SWITCH_LIM:  limit_r      <= $signed(pwdata[TEMP_W-1:0]);
        REG_TARGET_STEP: step_r       <= pwdata[STEP_W-1:0];
        REG_TARGET_MIN:  tmin_r       <= pwdata[TGT_W-1:0];
        REG_TARGET_MAX:  tmax_r       <= pwdata[TGT_W-1:0];
        REG_HOLD_TICKS:  hold_r       <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Track brightness times bar span, used by the bar length math
  assign bar_scale_nxt = BSCALE_W'(brightness_r) * BSCALE_W'(PIXEL_COUNT - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_scale_r <= BSCALE_W'(BRIGHT_RST) * BSCALE_W'(PIXEL_COUNT - 1);
    end else begin
      bar_scale_r <= bar_scale_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BRIGHTNESS:  prdata = APB_DATA_W'(brightness_r);
      REG_SWITCH_LIM:  prdata = APB_DATA_W'(unsigned'(limit_r));
      REG_TARGET_STEP: prdata = APB_DATA_W'(step_r);
      REG_TARGET_MIN:  prdata = APB_DATA_W'(tmin_r);
      REG_TARGET_MAX:  prdata = APB_DATA_W'(tmax_r);
      REG_HOLD_TICKS:  prdata = APB_DATA_W'(hold_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.brightness        = brightness_r;
    cfg.switch_temp_limit = limit_r;
    cfg.target_step       = step_r;
    cfg.target_min        = tmin_r;
    cfg.target_max        = tmax_r;
    cfg.hold_ticks        = hold_r;
    cfg.bar_scale         = bar_scale_r;
  end

endmodule

`default_nettype wire

/* design/htbd_front.sv */
// Front end: accepts ticks, updates target, filter and display mode, and
// classifies each tick into a frame command. Depends on htbd_pkg, htbd_in_if.
`default_nettype none
`include "hotplate_thermostat_bar_display_unit_assert.svh"

module htbd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  htbd_in_if.sink                          in_ch,
  input  wire htbd_pkg::cfg_t              cfg,
  input  wire logic [htbd_pkg::QCNT_W-1:0] q_count,
  output logic                             push,
  output htbd_pkg::frame_t                 push_data
);
  import htbd_pkg::*;

  // Tick state
  logic signed [FILT_W-1:0] filt_r, filt_nxt;
  logic [TGT_W-1:0]         target_r, target_nxt;
  mode_t                    mode_r, mode_nxt, mode_eff;
  logic [HOLD_W-1:0]        hold_r, hold_nxt, hold_inc;
  draw_t                    kind;

  logic                     accept;
  logic                     pressed;
  logic [TGT_W:0]           t_sum;
  logic [TGT_W:0]           t_floor;
  logic [TGT_W-1:0]         t_up;
  logic [QCNT_W:0]          occ;

  logic signed [FN_W-1:0]   fn_s;
  logic [DIV10_P_W-1:0]     div10_p;
  logic [FILT_W-1:0]        div10_q;

  // Stage 1
  logic                     s1_v_r;
  draw_t                    s1_kind_r;
  logic signed [FILT_W-1:0] s1_filt_r;
  logic [TGT_W-1:0]         s1_tgt_r;
  logic signed [TEMP_W-1:0] s1_sw_r;
  logic                     s1_heat, s1_over;
  logic [FILT_W-2:0]        s1_fpos;
  logic [PROD_W-1:0]        s1_prod;
  logic signed [DOT_W-1:0]  s1_dnum;

  // Stage 2
  logic                     s2_v_r;
  draw_t                    s2_kind_r;
  logic                     s2_heat_r, s2_over_r;
  logic [PROD_W-1:0]        s2_prod_r;
  logic signed [DOT_W-1:0]  s2_dnum_r;
  logic [U_W-1:0]           s2_u;
  logic [QP_W-1:0]          s2_qp;
  logic [BARQ_W-1:0]        s2_q;
  logic [DOTP_W-1:0]        s2_dp;
  logic [DOTPOS_W-1:0]      s2_pos;

  // Take a beat while the queue has room for every tick in flight
  assign occ         = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_v_r)
                     + (QCNT_W + 1)'(s2_v_r);
  assign in_ch.ready = occ < (QCNT_W + 1)'(QDEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  // Step the target: up first, then down, saturating at the limits
  assign pressed = in_ch.up_press || in_ch.down_press;
  assign t_sum   = {1'b0, target_r} + (TGT_W + 1)'(cfg.target_step);
  assign t_floor = {1'b0, cfg.target_min} + (TGT_W + 1)'(cfg.target_step);

  always_comb begin
    t_up = target_r;
    if (in_ch.up_press && (target_r < cfg.target_max)) begin
      t_up = (t_sum > {1'b0, cfg.target_max}) ? cfg.target_max : t_sum[TGT_W-1:0];
    end
    target_nxt = t_up;
    if (in_ch.down_press && (t_up > cfg.target_min)) begin
      target_nxt = ({1'b0, t_up} >= t_floor) ? (t_up - TGT_W'(cfg.target_step))
                                             : cfg.target_min;
    end
  end

  // Filter: floor((9f + 16c + 5) / 10), numerator offset to stay positive
  assign fn_s     = (FN_W'(filt_r) <<< 3) + FN_W'(filt_r)
                  + (FN_W'(in_ch.coil_temp) <<< 4) + FN_W'(FILT_BIAS);
  assign div10_p  = DIV10_P_W'(fn_s[DIV10_IN_W-1:0]) * DIV10_P_W'(REC10);
  assign div10_q  = div10_p[REC10_SHIFT +: FILT_W];
  assign filt_nxt = $signed(div10_q - FILT_OFS);

  // Mode machine: next state
  assign mode_eff = pressed ? MODE_TO_TARGET : mode_r;
  assign hold_inc = hold_r + HOLD_W'(1);

  always_comb begin
    unique case (mode_eff)
      MODE_STARTUP:   mode_nxt = MODE_TEMP;
      MODE_TEMP:      mode_nxt = MODE_TEMP;
      MODE_TARGET:    mode_nxt = (hold_inc >= cfg.hold_ticks) ? MODE_TO_TEMP : MODE_TARGET;
      MODE_TO_TARGET: mode_nxt = MODE_TARGET;
      MODE_TO_TEMP:   mode_nxt = MODE_TEMP;
      default:        mode_nxt = mode_eff;
    endcase
  end

  // Mode machine: outputs
  always_comb begin
    kind     = DRAW_NONE;
    hold_nxt = hold_r;
    unique case (mode_eff)
      MODE_STARTUP:   kind = DRAW_BLACK;
      MODE_TEMP:      kind = DRAW_BAR;
      MODE_TARGET: begin
        kind     = DRAW_DOT;
        hold_nxt = hold_inc;
      end
      MODE_TO_TARGET: hold_nxt = '0;
      MODE_TO_TEMP:   kind = DRAW_NONE;
      default:        kind = DRAW_NONE;
    endcase
  end

  // Commit tick state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      target_r <= TARGET_RST;
      mode_r   <= MODE_STARTUP;
      hold_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      if (accept) begin
        filt_r   <= filt_nxt;
        target_r <= target_nxt;
        mode_r   <= mode_nxt;
        hold_r   <= hold_nxt;
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= kind;
      s1_filt_r <= filt_nxt;
      s1_tgt_r  <= target_nxt;
      s1_sw_r   <= in_ch.switch_temp;
    end
  end

  // Stage 1: heater decision, bar product, dot numerator
  assign s1_over = s1_sw_r > cfg.switch_temp_limit;
  assign s1_heat = (s1_filt_r < $signed({3'b000, s1_tgt_r, 8'h00}))
                && (s1_sw_r < cfg.switch_temp_limit);
  assign s1_fpos = (s1_filt_r > 0) ? s1_filt_r[FILT_W-2:0] : '0;
  assign s1_prod = PROD_W'(s1_fpos) * PROD_W'(cfg.bar_scale);
  assign s1_dnum = $signed(DOT_N - DOT_W'(s1_tgt_r) * DOT_W'(PIXEL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_kind_r <= s1_kind_r;
      s2_heat_r <= s1_heat;
      s2_over_r <= s1_over;
      s2_prod_r <= s1_prod;
      s2_dnum_r <= s1_dnum;
    end
  end

  // Stage 2: divide bar product by 45, dot numerator by 90
  assign s2_u   = U_W'(s2_prod_r >> BAR_SHIFT);
  assign s2_qp  = QP_W'(s2_u) * QP_W'(REC45);
  assign s2_q   = s2_qp[REC45_SHIFT +: BARQ_W];
  assign s2_dp  = DOTP_W'(s2_dnum_r[DOTM_W-1:0]) * DOTP_W'(REC90);
  assign s2_pos = s2_dp[REC90_SHIFT +: DOTPOS_W];

  assign push = s2_v_r;

  always_comb begin
    push_data.heat    = s2_heat_r;
    push_data.over    = s2_over_r;
    push_data.kind    = s2_kind_r;
    push_data.bar     = s2_q[BARQ_W-1] ? {BAR_W{1'b1}} : s2_q[BAR_W-1:0];
    push_data.dot_hit = !s2_dnum_r[DOT_W-1] && (s2_pos < DOTPOS_W'(PIXEL_COUNT));
    push_data.dot_pos = s2_pos[PIX_IDX_W-1:0];
  end

  `HTBD_ASSERT_NEXT(a_press_enters_dot, accept && pressed,
    mode_r == MODE_TARGET && hold_r == '0, "press did not move to target dot")

endmodule

`default_nettype wire

/* design/htbd_queue.sv */
// Short command queue between front and back end of the bar display.
// Depends on htbd_pkg for frame_t and the queue depth.
`default_nettype none
`include "hotplate_thermostat_bar_display_unit_assert.svh"

module htbd_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire htbd_pkg::frame_t            push_data,
  input  wire logic                        pop,
  output htbd_pkg::frame_t                 rd_data,
  output logic [htbd_pkg::QCNT_W-1:0]      count
);
  import htbd_pkg::*;

  frame_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = cnt_r;

  `HTBD_ASSERT_NOW(a_no_overflow, push && !pop, cnt_r < QCNT_W'(QDEPTH),
    "queue push while full")
  `HTBD_ASSERT_NOW(a_no_underflow, pop, cnt_r != '0, "queue pop while empty")

endmodule

`default_nettype wire

/* design/htbd_back.sv */
// Back end: expands each command into pixel beats or a status beat, one per
// cycle unless stalled, via an output register. Uses htbd_pkg, htbd_out_if.
`default_nettype none
`include "hotplate_thermostat_bar_display_unit_assert.svh"

module htbd_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire htbd_pkg::cfg_t              cfg,
  input  wire htbd_pkg::frame_t            q_data,
  input  wire logic [htbd_pkg::QCNT_W-1:0] q_count,
  output logic                             pop,
  htbd_out_if.source                       out_ch
);
  import htbd_pkg::*;

  logic                       cur_v_r;
  frame_t                     cur_r;
  logic [PIX_IDX_W-1:0]       k_r;
  logic [BSCALE_W-1:0]        acc_r;

  logic                       out_v_r;
  logic                       out_heat_r, out_over_r, out_pv_r, out_last_r;
  logic [PIDX_W-1:0]          out_idx_r;
  logic [LEVEL_W-1:0]         out_green_r, out_red_r;

  logic                       q_valid;
  logic                       advance, emit, done, load;
  logic                       draw, is_last;
  logic [BAR_W:0]             diff;
  logic [BAR_W-1:0]           rem;
  logic [LEVEL_W-1:0]         green, red;
  logic [PIX_IDX_W+PIDX_W-1:0] idx_ext;

  assign q_valid = q_count != '0;
  assign advance = !out_v_r || out_ch.ready;
  assign draw    = cur_r.kind != DRAW_NONE;
  assign is_last = draw ? (k_r == PIX_IDX_W'(PIXEL_COUNT - 1)) : 1'b1;
  assign emit    = advance && cur_v_r;
  assign done    = emit && is_last;
  assign load    = q_valid && (!cur_v_r || done);
  assign pop     = load;

  // Bar pixel: what is left after the pixels above it, capped at brightness
  assign diff = {1'b0, cur_r.bar} - (BAR_W + 1)'(acc_r);
  assign rem  = diff[BAR_W] ? '0 : diff[BAR_W-1:0];

  always_comb begin
    green = '0;
    red   = '0;
    if ((cur_r.kind == DRAW_BAR) && (k_r != '0)) begin
      green = (rem >= BAR_W'(cfg.brightness)) ? cfg.brightness : rem[LEVEL_W-1:0];
    end
    if ((cur_r.kind == DRAW_DOT) && cur_r.dot_hit && (k_r == cur_r.dot_pos)) begin
      red = cfg.brightness;
    end
  end

  assign idx_ext = {PIDX_W'(0), k_r};

  // Sequence pixels of the current frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (load) begin
      cur_v_r <= 1'b1;
    end else if (done) begin
      cur_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
      k_r   <= '0;
      acc_r <= cfg.bar_scale;
    end else if (emit) begin
      k_r   <= k_r + PIX_IDX_W'(1);
      acc_r <= acc_r - BSCALE_W'(cfg.brightness);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= cur_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_heat_r  <= cur_r.heat;
      out_over_r  <= cur_r.over;
      out_pv_r    <= draw;
      out_idx_r   <= draw ? idx_ext[PIDX_W-1:0] : '0;
      out_green_r <= green;
      out_red_r   <= red;
      out_last_r  <= is_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.heater_on   = out_heat_r;
  assign out_ch.overtemp    = out_over_r;
  assign out_ch.pixel_valid = out_pv_r;
  assign out_ch.pixel_index = out_idx_r;
  assign out_ch.green_level = out_green_r;
  assign out_ch.red_level   = out_red_r;
  assign out_ch.last        = out_last_r;

  `HTBD_ASSERT_NOW(a_status_single, cur_v_r && (cur_r.kind == DRAW_NONE), k_r == '0,
    "non-drawing tick produced more than one beat")
  `HTBD_ASSERT_NOW(a_status_last, out_v_r && !out_pv_r, out_last_r,
    "status beat without last")

endmodule

`default_nettype wire

/* test/htbd_checker.sv */
// Scoreboard for the hotplate thermostat bar display: watches both channels and
// the register port, predicts every result beat and compares it on arrival.
// Depends on htbd_pkg and the htbd_in_if / htbd_out_if interfaces.

module htbd_checker
  import htbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  htbd_in_if                    in_mon,
  htbd_out_if                   out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    beats_due
);

  typedef struct packed {
    logic               heater_on;
    logic               overtemp;
    logic               pixel_valid;
    logic [PIDX_W-1:0]  pixel_index;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] red_level;
    logic               last;
  } pixel_beat_t;

  // Beats predicted but not yet seen on the result channel
  pixel_beat_t due_beats[$];

  // Register copies
  logic [BRIGHT_W-1:0]      bright;
  logic signed [TEMP_W-1:0] sw_limit;
  logic [STEP_W-1:0]        tgt_step;
  logic [TGT_W-1:0]         tgt_min;
  logic [TGT_W-1:0]         tgt_max;
  logic [HOLD_W-1:0]        hold_ticks;

  // Controller state: filter in 1/256 degC, target in whole degrees
  int                filt;
  int                target;
  mode_t             mode;
  logic [HOLD_W-1:0] hold_cnt;

  function automatic int floor_div10(input int n);
    if (n >= 0) return n / 10;
    return -((-n + 9) / 10);
  endfunction

  function automatic string beat_str(input pixel_beat_t b);
    return $sformatf("heat=%0b over=%0b pv=%0b idx=%0d g=%0d r=%0d last=%0b",
                     b.heater_on, b.overtemp, b.pixel_valid, b.pixel_index,
                     b.green_level, b.red_level, b.last);
  endfunction

  // Advance the controller by one tick and queue the beats it emits
  task automatic thermostat_tick(input logic signed [TEMP_W-1:0] coil,
                                 input logic signed [TEMP_W-1:0] sw,
                                 input logic up, input logic down);
    logic [LEVEL_W-1:0] green [PIXEL_COUNT];
    logic [LEVEL_W-1:0] red [PIXEL_COUNT];
    int          mx, mn, st, br, num, i, n;
    longint      bar_len;
    logic        draw, heat, over;
    pixel_beat_t b;
    mx = tgt_max;
    mn = tgt_min;
    st = tgt_step;
    br = bright;
    draw = 1'b0;

    // Step the target: up first, then down, each saturating at its limit
    if (up || down) begin
      if (up && target < mx) target = (target + st > mx) ? mx : target + st;
      if (down && target > mn) target = (target >= mn + st) ? target - st : mn;
      target = target & 127;
      mode = MODE_TO_TARGET;
    end

    filt = floor_div10(9 * filt + 16 * int'(coil) + 5);
    heat = (filt < target * 256) && (sw < sw_limit);
    over = sw > sw_limit;

    for (i = 0; i < PIXEL_COUNT; i++) begin
      green[i] = '0;
      red[i] = '0;
    end

    case (mode)
      MODE_STARTUP: begin
        draw = 1'b1;
        mode = MODE_TEMP;
      end
      MODE_TEMP: begin
        // Fill from the top pixel down, full pixels then one partial
        bar_len = 0;
        if (filt > 0) begin
          bar_len = longint'(filt) * (PIXEL_COUNT - 1) * br / (FULL_SCALE_DEG * 256);
          if (bar_len > 65535) bar_len = 65535;
        end
        for (i = PIXEL_COUNT - 1; i > 0; i--) begin
          if (bar_len >= br) begin
            green[i] = LEVEL_W'(br);
            bar_len -= br;
          end else if (bar_len > 0) begin
            green[i] = LEVEL_W'(bar_len);
            bar_len = 0;
          end
        end
        draw = 1'b1;
      end
      MODE_TARGET: begin
        // Dot falls off the strip for target 0 or above 99 degrees
        num = FULL_SCALE_DEG * PIXEL_COUNT - target * (PIXEL_COUNT - 1);
        if (num >= 0 && num / FULL_SCALE_DEG < PIXEL_COUNT)
          red[num / FULL_SCALE_DEG] = bright;
        draw = 1'b1;
        hold_cnt = hold_cnt + 1'b1;
        if (hold_cnt >= hold_ticks) mode = MODE_TO_TEMP;
      end
      MODE_TO_TARGET: begin
        hold_cnt = '0;
        mode = MODE_TARGET;
      end
      MODE_TO_TEMP: begin
        mode = MODE_TEMP;
      end
      default: begin
      end
    endcase

    n = draw ? PIXEL_COUNT : 1;
    for (i = 0; i < n; i++) begin
      b.heater_on   = heat;
      b.overtemp    = over;
      b.pixel_valid = draw;
      b.pixel_index = draw ? PIDX_W'(i) : '0;
      b.green_level = draw ? green[i] : '0;
      b.red_level   = draw ? red[i] : '0;
      b.last        = (i == n - 1);
      due_beats.push_back(b);
    end
  endtask

  // Track registers, predict on input beats, compare on result beats
  always @(posedge clk) begin
    pixel_beat_t got, want;
    if (!rst_n) begin
      bright     = BRIGHT_RST;
      sw_limit   = LIMIT_RST;
      tgt_step   = STEP_RST;
      tgt_min    = TMIN_RST;
      tgt_max    = TMAX_RST;
      hold_ticks = HOLD_RST;
      filt       = 0;
      target     = TARGET_RST;
      mode       = MODE_STARTUP;
      hold_cnt   = '0;
      mismatches = 0;
      due_beats.delete();
    end else begin
      // Check the result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.heater_on   = out_mon.heater_on;
        got.overtemp    = out_mon.overtemp;
        got.pixel_valid = out_mon.pixel_valid;
        got.pixel_index = out_mon.pixel_index;
        got.green_level = out_mon.green_level;
        got.red_level   = out_mon.red_level;
        got.last        = out_mon.last;
        if (due_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got %s", $time, beat_str(got));
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: beat mismatch, expected %s, got %s", $time,
                     beat_str(want), beat_str(got));
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        thermostat_tick(in_mon.coil_temp, in_mon.switch_temp,
                        in_mon.up_press, in_mon.down_press);

      // Mirror register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[REG_ADDR_W-1:2]))
          REG_BRIGHTNESS:  bright     = pwdata[BRIGHT_W-1:0];
          REG_SWITCH_LIM:  sw_limit   = pwdata[TEMP_W-1:0];
          REG_TARGET_STEP: tgt_step   = pwdata[STEP_W-1:0];
          REG_TARGET_MIN:  tgt_min    = pwdata[TGT_W-1:0];
          REG_TARGET_MAX:  tgt_max    = pwdata[TGT_W-1:0];
          REG_HOLD_TICKS:  hold_ticks = pwdata[HOLD_W-1:0];
          default: begin
          end
        endcase
      end
    end
    beats_due = due_beats.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the thermostat bar display testbench: clock, reset, tick stimulus,
// result back-pressure and register programming; htbd_checker does the checks.
// Depends on htbd_pkg, the channel interfaces, the block and htbd_checker.

module tb_top;
  import htbd_pkg::*;

  localparam int GAP_MAX         = 17;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                       fail_count;
  int                       beats_pending;
  bit                       tx_gaps_on;
  bit                       rx_stalls_on;
  bit                       flood;
  bit                       hold_off_req;
  int                       coil_level;
  int                       press_pct;
  logic signed [TEMP_W-1:0] cur_limit;

  htbd_in_if  in_ch ();
  htbd_out_if out_ch ();

  hotplate_thermostat_bar_display_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  htbd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (fail_count),
    .beats_due  (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL hotplate_thermostat_bar_display_unit");
    $finish;
  end

  // Result side: before each beat, stall randomly while stalls are on, or hold off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    rx_stalls_on = 1'b1;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) rx_stalls_on = !rx_stalls_on;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Offer one tick, after a random gap unless gaps are off or flooding, and hold it until taken
  task automatic send_tick(input int coil, input int sw, input logic up,
                           input logic down);
    int gap;
    gap = (tx_gaps_on && !flood) ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.coil_temp   <= TEMP_W'(coil);
    in_ch.switch_temp <= TEMP_W'(sw);
    in_ch.up_press    <= up;
    in_ch.down_press  <= down;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input int data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(int'(idx) * 4);
    pwdata  <= APB_DATA_W'(data);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input int br, input int lim, input int st,
                              input int mn, input int mx, input int hd);
    reg_write(REG_BRIGHTNESS, br);
    reg_write(REG_SWITCH_LIM, lim);
    reg_write(REG_TARGET_STEP, st);
    reg_write(REG_TARGET_MIN, mn);
    reg_write(REG_TARGET_MAX, mx);
    reg_write(REG_HOLD_TICKS, hd);
    cur_limit = TEMP_W'(lim);
  endtask

  // Drop valid and let every predicted beat come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (beats_pending == 0);
    repeat (8) @(negedge clk);
  endtask

  // Random ticks: coil mostly drifts, switch mostly hugs the limit
  task automatic run_ticks(input int count);
    int   k, r, coil, sw;
    logic up, down;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 31) == 0) tx_gaps_on = !tx_gaps_on;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        coil_level += int'($urandom_range(0, 240)) - 120;
        if (coil_level < -640) coil_level = -640;
        if (coil_level > 4800) coil_level = 4800;
        coil = coil_level;
      end else if (r < 90) begin
        coil = int'($urandom_range(0, 5440)) - 640;
      end else begin
        coil = int'($urandom_range(0, 16383)) - 8192;
      end
      r = $urandom_range(0, 99);
      if (r < 60) sw = int'(cur_limit) + int'($urandom_range(0, 64)) - 32;
      else if (r < 90) sw = int'($urandom_range(0, 5440)) - 640;
      else sw = int'($urandom_range(0, 16383)) - 8192;
      up   = ($urandom_range(0, 99) < press_pct);
      down = ($urandom_range(0, 99) < press_pct);
      send_tick(coil, sw, up, down);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.coil_temp   = '0;
    in_ch.switch_temp = '0;
    in_ch.up_press    = 1'b0;
    in_ch.down_press  = 1'b0;
    tx_gaps_on        = 1'b1;
    flood             = 1'b0;
    hold_off_req      = 1'b0;
    coil_level        = 400;
    press_pct         = 15;
    cur_limit         = LIMIT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: startup frame, field extremes, limit edges, saturating
    // presses, both buttons at once, and the dot hold running out
    program_regs(16, 800, 40, 10, 90, 3);
    send_tick(0, 0, 1'b0, 1'b0);
    send_tick(8191, 801, 1'b0, 1'b0);
    send_tick(-8192, -8192, 1'b0, 1'b0);
    send_tick(4800, 800, 1'b0, 1'b0);
    send_tick(4800, 799, 1'b1, 1'b0);
    send_tick(4800, 8191, 1'b0, 1'b0);
    send_tick(-640, -640, 1'b1, 1'b0);
    send_tick(0, 0, 1'b1, 1'b1);
    send_tick(2000, 0, 1'b0, 1'b0);
    send_tick(2000, 0, 1'b0, 1'b1);
    send_tick(2000, 0, 1'b0, 1'b1);
    send_tick(2000, 0, 1'b0, 1'b0);
    send_tick(2000, 0, 1'b0, 1'b0);
    send_tick(2000, 0, 1'b0, 1'b0);
    send_tick(2000, 0, 1'b0, 1'b0);
    send_tick(4800, 4801, 1'b0, 1'b0);
    send_tick(1234, -8192, 1'b0, 1'b0);
    drain();

    // Zero brightness, full target range so the dot leaves the strip, no hold
    program_regs(0, -8192, 63, 0, 127, 0);
    press_pct = 30;
    run_ticks(60);
    drain();

    // Full brightness, widest limit, smallest step, longest hold
    program_regs(255, 8191, 1, 1, 90, 255);
    press_pct = 20;
    run_ticks(60);
    drain();

    // Inverted target limits
    program_regs(1, -640, 45, 90, 1, 1);
    press_pct = 30;
    run_ticks(60);
    drain();

    // Power-on values, rare presses
    program_regs(16, 800, 10, 10, 90, 100);
    press_pct = 5;
    run_ticks(80);
    drain();

    // Random setting; hold off results while ticks keep coming
    program_regs($urandom_range(1, 255), int'($urandom_range(0, 5440)) - 640,
                 $urandom_range(1, 45), $urandom_range(1, 90), $urandom_range(1, 90),
                 $urandom_range(1, 20));
    press_pct = 8;
    run_ticks(20);
    hold_off_req = 1'b1;
    flood = 1'b1;
    run_ticks(40);
    flood = 1'b0;
    run_ticks(10);
    drain();

    // Random setting; pause input until every result is out
    program_regs($urandom_range(1, 255), int'($urandom_range(0, 5440)) - 640,
                 $urandom_range(1, 45), $urandom_range(1, 90), $urandom_range(1, 90),
                 $urandom_range(1, 20));
    press_pct = 10;
    run_ticks(30);
    in_ch.valid <= 1'b0;
    wait (beats_pending == 0);
    @(negedge clk);
    run_ticks(40);
    drain();
    repeat (12) @(negedge clk);

    if (fail_count == 0) begin
      $display("PASS hotplate_thermostat_bar_display_unit");
    end else begin
      $display("FAIL hotplate_thermostat_bar_display_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/htbd_pkg.sv
design/htbd_in_if.sv
design/htbd_out_if.sv
design/htbd_regs.sv
design/htbd_front.sv
design/htbd_queue.sv
design/htbd_back.sv
design/hotplate_thermostat_bar_display_unit.sv
test/htbd_checker.sv
test/tb_top.sv
